// File: hdl/dhrp_pkg.sv
`default_nettype none
package dhrp_pkg;

    localparam int unsigned CS_W       = 32;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned SC_W       = 7;
    localparam int unsigned RL_W       = 9;
    localparam int unsigned SERVER_W   = 6;
    localparam int unsigned HELD_W     = 9;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned DIV_STEPS  = 33;
    localparam int unsigned DIV_CNT_W  = 6;

    localparam logic [CS_W-1:0] H1_MUL     = 32'd7919;
    localparam logic [CS_W-1:0] H2_MUL     = 32'd104729;
    localparam logic [CS_W-1:0] H2_ADD     = 32'd123;
    localparam logic [CH_W-1:0] SPACE_CHAR = 8'h20;

    localparam logic REG_SERVER_COUNT  = 1'b0;
    localparam logic REG_REQUEST_LIMIT = 1'b1;

    typedef struct packed {
        logic            valid;
        logic [CS_W-1:0] cs;
    } dhrp_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_RD,
        ST_CHK,
        ST_OUT
    } dhrp_state_t;

endpackage
`default_nettype wire

// File: hdl/dhrp_ram.sv
`default_nettype none
module dhrp_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/dhrp_front.sv
`default_nettype none
module dhrp_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     enable,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [dhrp_pkg::CH_W-1:0] in_ch,
    input  wire logic                     in_no_char,
    input  wire logic                     in_last,
    output dhrp_pkg::dhrp_req_t           head,
    input  wire logic                     pop
);
    import dhrp_pkg::*;

    logic [CS_W-1:0] cs_reg, cs_next;
    logic            seen_reg, seen_next;
    logic [CS_W-1:0] q_mem [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            accept, push;
    logic [CS_W-1:0] sext, push_cs;

    assign in_ready = enable && (cnt_reg != 2'd2);
    assign accept   = in_valid && in_ready;
    assign push     = accept && in_last;
    assign sext     = {{(CS_W-CH_W){in_ch[CH_W-1]}}, in_ch};

    always_comb
    begin
        cs_next   = cs_reg;
        seen_next = seen_reg;
        if (!in_no_char)
        begin
            if (!seen_reg)
            begin
                cs_next   = sext;
                seen_next = 1'b1;
            end
            else if (in_ch != SPACE_CHAR)
            begin
                cs_next = cs_reg ^ sext;
            end
        end
        push_cs = seen_next ? cs_next : '0;
        // clear at request end
        if (in_last)
        begin
            cs_next   = '0;
            seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg     <= '0;
            seen_reg   <= 1'b0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                cs_reg   <= cs_next;
                seen_reg <= seen_next;
            end
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_cs;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.cs    = q_mem[rd_ptr_reg];
endmodule
`default_nettype wire

// File: hdl/dhrp_div.sv
`default_nettype none
module dhrp_div #(
    parameter int unsigned NW = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [NW-1:0]              n,
    input  wire logic [dhrp_pkg::CS_W-1:0]  a,
    input  wire logic [dhrp_pkg::CS_W-1:0]  b,
    output logic                            done,
    output logic      [NW-1:0]              ra,
    output logic      [NW-1:0]              rb,
    output logic      [NW-1:0]              rp
);
    import dhrp_pkg::*;

    logic [CS_W:0]      sa_reg, sb_reg;
    logic [NW-1:0]      ra_reg, rb_reg, rp_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic               busy_reg, done_reg;

    function automatic logic [NW-1:0] mstep(input logic [NW-1:0] r, input logic bt,
                                            input logic [NW-1:0] d);
        logic [NW:0] t;
        t = {r, bt};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[NW-1:0];
    endfunction

    // restoring remainder, one bit a cycle, three lanes: a, b and 2^32
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sa_reg <= {1'b0, a};
            sb_reg <= {1'b0, b};
            ra_reg <= '0;
            rb_reg <= '0;
            rp_reg <= '0;
        end
        else if (busy_reg)
        begin
            sa_reg <= {sa_reg[CS_W-1:0], 1'b0};
            sb_reg <= {sb_reg[CS_W-1:0], 1'b0};
            ra_reg <= mstep(ra_reg, sa_reg[CS_W], n);
            rb_reg <= mstep(rb_reg, sb_reg[CS_W], n);
            rp_reg <= mstep(rp_reg, (cnt_reg == '0), n);
        end
    end

    assign done = done_reg;
    assign ra   = ra_reg;
    assign rb   = rb_reg;
    assign rp   = rp_reg;
endmodule
`default_nettype wire

// File: hdl/dhrp_back.sv
`default_nettype none
module dhrp_back #(
    parameter int unsigned NUM_SERVERS  = 64,
    parameter int unsigned MAX_REQUESTS = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [dhrp_pkg::SC_W-1:0]           server_count,
    input  wire logic [dhrp_pkg::RL_W-1:0]           request_limit,
    input  wire dhrp_pkg::dhrp_req_t                 head,
    output logic                                     pop,
    output logic                                     clearing,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [dhrp_pkg::OUT_TDATA_W-1:0]    out_data
);
    import dhrp_pkg::*;

    localparam int unsigned NW = $clog2(NUM_SERVERS + 1);
    localparam int unsigned AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
    localparam int unsigned LW = (CW > RL_W) ? CW : RL_W;

    dhrp_state_t     state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [CS_W-1:0] cs_reg, cs_next;
    logic [CS_W-1:0] h1_reg, h1_next, h2_reg, h2_next;
    logic [CS_W-1:0] x_reg, x_next;
    logic [NW-1:0]   r_reg, r_next, b_reg, b_next, c_reg, c_next;
    logic [NW-1:0]   i_reg, i_next, first_reg, first_next;
    logic [NW-1:0]   srv_reg, srv_next;
    logic            redir_reg, redir_next, fail_reg, fail_next;
    logic [CW-1:0]   held_reg, held_next;
    logic            ov_reg, ov_next;
    logic [OUT_TDATA_W-1:0] od_reg, od_next;

    logic [NW-1:0]   n_eff;
    logic [LW-1:0]   lim;
    logic            div_start, div_done;
    logic [NW-1:0]   div_ra, div_rb, div_rp;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [CW-1:0]   ram_wdata, ram_rdata;
    logic [CS_W:0]   xsum;
    logic [NW:0]     s0, s1, s2;

    assign n_eff = (server_count == '0) ? NW'(1)
                 : (32'(server_count) > NUM_SERVERS) ? NW'(NUM_SERVERS) : NW'(server_count);
    assign lim   = (32'(request_limit) > MAX_REQUESTS) ? LW'(MAX_REQUESTS) : LW'(request_limit);

    dhrp_div #(.NW(NW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (n_eff),
        .a     (h1_reg),
        .b     (h2_reg),
        .done  (div_done),
        .ra    (div_ra),
        .rb    (div_rb),
        .rp    (div_rp)
    );

    dhrp_ram #(.WIDTH(CW), .DEPTH(NUM_SERVERS)) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (r_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // next probe: track (h1 + i*h2) mod 2^32 and its remainder mod n together
    assign xsum = {1'b0, x_reg} + {1'b0, h2_reg};

    always_comb
    begin
        s0 = {1'b0, r_reg} + {1'b0, b_reg};
        s1 = (s0 >= {1'b0, n_eff}) ? s0 - {1'b0, n_eff} : s0;
        s2 = s1;
        if (xsum[CS_W])
        begin
            s2 = (s1 >= {1'b0, c_reg}) ? s1 - {1'b0, c_reg}
                                       : s1 + {1'b0, n_eff} - {1'b0, c_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cs_next    = cs_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        i_next     = i_reg;
        first_next = first_reg;
        srv_next   = srv_reg;
        redir_next = redir_reg;
        fail_next  = fail_reg;
        held_next  = held_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_reg[AW-1:0];
        ram_wdata  = ram_rdata + 1'b1;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == NUM_SERVERS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    cs_next    = head.cs;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                h1_next    = cs_reg * H1_MUL;
                h2_next    = cs_reg * H2_MUL + H2_ADD;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    r_next     = div_ra;
                    first_next = div_ra;
                    b_next     = div_rb;
                    c_next     = div_rp;
                    x_next     = h1_reg;
                    i_next     = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (LW'(ram_rdata) < lim)
                begin
                    ram_we     = 1'b1;
                    srv_next   = r_reg;
                    redir_next = (i_reg != '0);
                    held_next  = ram_wdata;
                    fail_next  = 1'b0;
                    state_next = ST_OUT;
                end
                else if (i_reg == n_eff - 1'b1)
                begin
                    srv_next   = '0;
                    redir_next = 1'b0;
                    held_next  = '0;
                    fail_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    r_next     = s2[NW-1:0];
                    x_next     = xsum[CS_W-1:0];
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    od_next    = {1'b0, fail_reg, HELD_W'(held_reg), redir_reg,
                                  SERVER_W'(first_reg), SERVER_W'(srv_reg)};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cs_reg    <= cs_next;
        h1_reg    <= h1_next;
        h2_reg    <= h2_next;
        x_reg     <= x_next;
        r_reg     <= r_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        i_reg     <= i_next;
        first_reg <= first_next;
        srv_reg   <= srv_next;
        redir_reg <= redir_next;
        fail_reg  <= fail_next;
        held_reg  <= held_next;
        od_reg    <= od_next;
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule
`default_nettype wire

// File: hdl/double_hash_request_placer.sv
// Channel | Beat fields (low bit up)                              | Direction
// s_axis  | tdata: ch; tuser: no_char; tlast: last                | in
// m_axis  | tdata: server, first_server, redirected, held_count,  | out
//         |        fail, pad bit                                  |
// cfg     | index 0 server_count, index 1 request_limit; cfg_data | in
// Characters are taken one per cycle unless a beat waits, which it does while the
// queue is full or the count memory is being cleared. In the back end a request end
// goes through multiply, divider start, the bit-serial remainder unit and p probes,
// p being 1..effective server count; each probe is one read and one check on the
// count memory. After reset the memory is cleared one entry a cycle, all NUM_SERVERS
// entries, with s_tready low meanwhile. A two-entry queue lets characters flow while
// the back end probes; once cleared, s_tready drops only when both hold pending ends.
`default_nettype none
module double_hash_request_placer #(
    parameter int unsigned NUM_SERVERS  = 64,
    parameter int unsigned MAX_REQUESTS = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [dhrp_pkg::CH_W-1:0]           s_tdata,  // [7:0] ch
    input  wire logic                                s_tuser,  // [0] no_char
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [5:0] server, [11:6] first_server, [12] redirected, [21:13] held_count,
    // [22] fail, [23] zero
    output logic      [dhrp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [dhrp_pkg::RL_W-1:0]           cfg_data
);
    import dhrp_pkg::*;

    logic [SC_W-1:0] sc_reg;
    logic [RL_W-1:0] rl_reg;
    dhrp_req_t       head;
    logic            pop, clearing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= SC_W'(64);
            rl_reg <= RL_W'(8);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SERVER_COUNT:  sc_reg <= cfg_data[SC_W-1:0];
                REG_REQUEST_LIMIT: rl_reg <= cfg_data;
                default:           rl_reg <= rl_reg;
            endcase
        end
    end

    dhrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (!clearing),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_ch      (s_tdata),
        .in_no_char (s_tuser),
        .in_last    (s_tlast),
        .head       (head),
        .pop        (pop)
    );

    dhrp_back #(
        .NUM_SERVERS  (NUM_SERVERS),
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .server_count  (sc_reg),
        .request_limit (rl_reg),
        .head          (head),
        .pop           (pop),
        .clearing      (clearing),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_data      (m_tdata)
    );
endmodule
`default_nettype wire

// File: hdl/dhrp_checker.sv
`default_nettype none
module dhrp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        cfg_index,
    input wire logic [8:0]  cfg_data
);
    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a failed placement reports no server, no redirect, no count
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[22] |-> m_tdata[21:0] == {9'd0, 1'b0, m_tdata[11:6], 6'd0})
        else $error("fail beat carries placement fields");

    // a placed request holds at least one
    a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[22] |-> m_tdata[21:13] != 9'd0)
        else $error("placed request with zero count");

    // without redirect the chosen server is the first probe
    a_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[22] && !m_tdata[12] |-> m_tdata[5:0] == m_tdata[11:6])
        else $error("direct placement off the first server");
endmodule

bind double_hash_request_placer dhrp_checker u_dhrp_checker (.*);
`default_nettype wire
